// File: rtl/hfc_pkg.sv
// heartbeat frame collector package
// shared types, codes and constants for the rtl folder; depends on nothing
package hfc_pkg;

  typedef enum logic [1:0] {
    OP_PUSH8  = 2'd0,
    OP_PUSH16 = 2'd1,
    OP_PUSH32 = 2'd2,
    OP_TICK   = 2'd3
  } opcode_e;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TASKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MESSAGE  = 2'd2;

  localparam logic [19:0] INTERVAL_RESET = 20'd100000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] push_value;
    logic [15:0] done_mask;
    logic [31:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic [2:0] byte_count;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic ld_push;
    logic tick_upd;
    logic hb_start;
    logic hb_coll;
    logic hb_msg;
    logic idle_inc;
    logic push_wr;
    logic set_err;
    logic err_last;
    logic word_clr;
    logic drn_rd;
    logic drn_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic push_ovf;
    logic push_last;
    logic all_done;
    logic tick_due;
    logic stack_empty;
    logic word_fill3;
    logic out_free;
    logic pend_err;
    logic pend_last;
  } sts_t;

endpackage

// File: rtl/hfc_if.sv
// valid/ready stream interfaces for input items and result words
// depends on hfc_pkg
interface hfc_in_if;
  logic               valid;
  logic               ready;
  hfc_pkg::in_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hfc_out_if;
  logic               valid;
  logic               ready;
  hfc_pkg::out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/hfc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 129
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hfc_ctrl.sv
// controller state machine: sequences pushes, ticks, heartbeat and drain
// depends on hfc_pkg
module hfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_is_tick_i,
  output logic          in_ready_o,
  input  hfc_pkg::sts_t sts_i,
  output hfc_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TICK = 7'b0000010,
    S_PCHK = 7'b0000100,
    S_PWR  = 7'b0001000,
    S_DRD  = 7'b0010000,
    S_DCAP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    HB_IDLE_CNT = 2'd0,
    HB_COLL_CNT = 2'd1,
    HB_MSG      = 2'd2
  } hb_step_e;

  state_e        state_q, state_d;
  hb_step_e      step_q, step_d;
  logic          hb_q, hb_d;
  hfc_pkg::cmd_t cmd;
  state_e        adv_state;
  hfc_pkg::cmd_t adv_cmd;
  hb_step_e      adv_step;

  // what follows a finished push
  always_comb begin
    adv_cmd   = '0;
    adv_step  = step_q;
    adv_state = S_IDLE;
    if (hb_q) begin
      case (step_q)
        HB_IDLE_CNT: begin
          adv_cmd.hb_coll = 1'b1;
          adv_step        = HB_COLL_CNT;
          adv_state       = S_PCHK;
        end
        HB_COLL_CNT: begin
          adv_cmd.hb_msg = 1'b1;
          adv_step       = HB_MSG;
          adv_state      = S_PCHK;
        end
        HB_MSG: begin
          adv_cmd.word_clr = 1'b1;
          adv_state        = S_DRD;
        end
        default: begin
          adv_state = S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    step_d     = step_q;
    hb_d       = hb_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          hb_d = 1'b0;
          if (in_is_tick_i) begin
            cmd.tick_upd = 1'b1;
            state_d      = S_TICK;
          end else begin
            cmd.ld_push = 1'b1;
            state_d     = S_PCHK;
          end
        end
      end
      S_TICK: begin
        state_d = S_IDLE;
        if (sts_i.all_done) begin
          if (sts_i.tick_due) begin
            cmd.hb_start = 1'b1;
            hb_d         = 1'b1;
            step_d       = HB_IDLE_CNT;
            state_d      = S_PCHK;
          end else begin
            cmd.idle_inc = 1'b1;
          end
        end
      end
      S_PCHK: begin
        if (sts_i.push_ovf) begin
          cmd.set_err  = 1'b1;
          cmd.err_last = ~hb_q;
          state_d      = S_OUT;
        end else begin
          state_d = S_PWR;
        end
      end
      S_PWR: begin
        cmd.push_wr = 1'b1;
        if (sts_i.push_last) begin
          cmd     = cmd | adv_cmd;
          step_d  = adv_step;
          state_d = adv_state;
        end
      end
      S_DRD: begin
        cmd.drn_rd = 1'b1;
        state_d    = S_DCAP;
      end
      S_DCAP: begin
        cmd.drn_cap = 1'b1;
        if (sts_i.word_fill3 || sts_i.stack_empty) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DRD;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          if (sts_i.pend_last) begin
            hb_d    = 1'b0;
            state_d = S_IDLE;
          end else if (sts_i.pend_err) begin
            cmd     = cmd | adv_cmd;
            step_d  = adv_step;
            state_d = adv_state;
          end else begin
            cmd.word_clr = 1'b1;
            state_d      = S_DRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= HB_IDLE_CNT;
      hb_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      hb_q    <= hb_d;
    end
  end

endmodule

// File: rtl/hfc_datapath.sv
// datapath: config registers, byte stack, task flags, counters, result register
// depends on hfc_pkg and hfc_ram
module hfc_datapath #(
  parameter int unsigned STACK_TOP_INDEX = 128,
  parameter int unsigned MAX_TASKS       = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hfc_pkg::cmd_t                    cmd_i,
  output hfc_pkg::sts_t                    sts_o,
  input  hfc_pkg::in_word_t                in_word_i,
  input  logic                             cfg_we_i,
  input  logic [hfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hfc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output hfc_pkg::out_word_t               out_word_o
);

  localparam int unsigned DEPTH = STACK_TOP_INDEX + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // config
  logic [19:0] interval_q;
  logic [4:0]  task_count_q;
  logic [7:0]  message_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= hfc_pkg::INTERVAL_RESET;
      task_count_q <= '0;
      message_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hfc_pkg::CFG_IDX_INTERVAL: interval_q   <= cfg_data_i[19:0];
        hfc_pkg::CFG_IDX_TASKS:    task_count_q <= cfg_data_i[4:0];
        hfc_pkg::CFG_IDX_MESSAGE:  message_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // tick counters
  logic [15:0] coll_q, idle_q;

  // push staging, value left aligned
  logic [31:0] pval_q, pval_d;
  logic [2:0]  pn_q, pn_d;

  always_comb begin
    pval_d = pval_q;
    pn_d   = pn_q;
    if (cmd_i.push_wr) begin
      pval_d = {pval_q[23:0], 8'h00};
      pn_d   = pn_q - 3'd1;
    end
    if (cmd_i.ld_push) begin
      case (hfc_pkg::opcode_e'(in_word_i.opcode))
        hfc_pkg::OP_PUSH8: begin
          pval_d = {in_word_i.push_value[7:0], 24'h0};
          pn_d   = 3'd1;
        end
        hfc_pkg::OP_PUSH16: begin
          pval_d = {in_word_i.push_value[15:0], 16'h0};
          pn_d   = 3'd2;
        end
        default: begin
          pval_d = in_word_i.push_value;
          pn_d   = 3'd4;
        end
      endcase
    end else if (cmd_i.hb_start) begin
      pval_d = {idle_q, 16'h0};
      pn_d   = 3'd2;
    end else if (cmd_i.hb_coll) begin
      pval_d = {coll_q, 16'h0};
      pn_d   = 3'd2;
    end else if (cmd_i.hb_msg) begin
      pval_d = {message_q, 24'h0};
      pn_d   = 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    pval_q <= pval_d;
    pn_q   <= pn_d;
  end

  // stack
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_dec;
  logic [CW:0]   fill_sum;
  logic [7:0]    rdata;

  assign count_dec = count_q - CW'(1);
  assign fill_sum  = {1'b0, count_q} + (CW + 1)'(pn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.push_wr) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.drn_rd) begin
      count_q <= count_dec;
    end
  end

  hfc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_wr),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (pval_q[31:24]),
    .re_i    (cmd_i.drn_rd),
    .raddr_i (count_dec[AW-1:0]),
    .rdata_o (rdata)
  );

  // task flags and tick counters
  logic [MAX_TASKS-1:0] task_done_q, task_upd;
  logic                 all_done_q, all_upd;
  logic [31:0]          mask32;
  logic [31:0]          next_due_q, now_q;

  assign mask32 = {16'h0, in_word_i.done_mask};

  always_comb begin
    task_upd = task_done_q;
    all_upd  = 1'b1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (6'(i) < {1'b0, task_count_q}) begin
        task_upd[i] = task_done_q[i] | mask32[i];
        all_upd     = all_upd & task_upd[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_done_q <= '0;
      all_done_q  <= 1'b0;
      coll_q      <= '0;
      idle_q      <= '0;
      next_due_q  <= '0;
    end else begin
      if (cmd_i.hb_start) begin
        task_done_q <= '0;
        all_done_q  <= 1'b0;
        idle_q      <= '0;
        next_due_q  <= now_q + {12'h0, interval_q};
      end else if (cmd_i.tick_upd && !all_done_q) begin
        task_done_q <= task_upd;
        all_done_q  <= all_upd;
        coll_q      <= coll_q + 16'd1;
      end else if (cmd_i.idle_inc) begin
        idle_q <= idle_q + 16'd1;
      end else if (cmd_i.hb_coll) begin
        coll_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_upd) begin
      now_q <= in_word_i.now_us;
    end
  end

  // pending word
  logic [3:0][7:0] wb_q, wb_d;
  logic [2:0]      wcnt_q, wcnt_d;
  logic            wkind_q, wkind_d;
  logic            wlast_q, wlast_d;

  always_comb begin
    wb_d    = wb_q;
    wcnt_d  = wcnt_q;
    wkind_d = wkind_q;
    wlast_d = wlast_q;
    if (cmd_i.set_err) begin
      wb_d    = '0;
      wcnt_d  = '0;
      wkind_d = hfc_pkg::KIND_ERROR;
      wlast_d = cmd_i.err_last;
    end else if (cmd_i.word_clr) begin
      wb_d    = '0;
      wcnt_d  = '0;
      wkind_d = hfc_pkg::KIND_DATA;
      wlast_d = 1'b0;
    end else if (cmd_i.drn_cap) begin
      wb_d[wcnt_q[1:0]] = rdata;
      wcnt_d            = wcnt_q + 3'd1;
      wlast_d           = (count_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    wb_q    <= wb_d;
    wcnt_q  <= wcnt_d;
    wkind_q <= wkind_d;
    wlast_q <= wlast_d;
  end

  // result register
  logic               out_valid_q;
  hfc_pkg::out_word_t out_word_q;
  logic               out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q.kind       <= wkind_q;
      out_word_q.byte_a     <= wb_q[0];
      out_word_q.byte_b     <= wb_q[1];
      out_word_q.byte_c     <= wb_q[2];
      out_word_q.byte_d     <= wb_q[3];
      out_word_q.byte_count <= wcnt_q;
      out_word_q.last       <= wlast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // status
  assign sts_o.push_ovf    = fill_sum > (CW + 1)'(DEPTH);
  assign sts_o.push_last   = (pn_q == 3'd1);
  assign sts_o.all_done    = all_done_q;
  assign sts_o.tick_due    = (now_q >= next_due_q);
  assign sts_o.stack_empty = (count_q == '0);
  assign sts_o.word_fill3  = (wcnt_q == 3'd3);
  assign sts_o.out_free    = out_free;
  assign sts_o.pend_err    = (wkind_q == hfc_pkg::KIND_ERROR);
  assign sts_o.pend_last   = wlast_q;

endmodule

// File: rtl/heartbeat_frame_collector_top.sv
// heartbeat frame collector top level
// the input channel in_i takes push and tick words, the output channel out_o
// gives frame data words and stack overflow error words; a plain write port
// sets interval_us (index 0), task_count (index 1) and message_code (index 2)
// a push has a fit check, then one stack ram write per byte; an overflowing
// push instead gives one error word; a tick updates the task flags, then
// checks them and the due time; a tick that sends a frame pushes five
// heartbeat bytes and then drains the stack top first, each byte through
// the ram's registered read port, up to four bytes per word
// one item is worked on at a time; ready is high only between items
// results sit in an output register, so the next item is accepted while the
// last word waits; a stalled receiver holds the frame drain at that word
// reset (rst_ni low, asynchronous) empties the stack, clears task flags,
// counters and the due time and loads the register defaults; stack contents
// are not cleared and no sweep is needed
module heartbeat_frame_collector_top #(
  parameter int unsigned STACK_TOP_INDEX = 128,
  parameter int unsigned MAX_TASKS       = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hfc_in_if.sink                         in_i,
  hfc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [hfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hfc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  hfc_pkg::cmd_t cmd;
  hfc_pkg::sts_t sts;
  logic          in_is_tick;

  assign in_is_tick = (hfc_pkg::opcode_e'(in_i.payload.opcode) == hfc_pkg::OP_TICK);

  hfc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_is_tick_i (in_is_tick),
    .in_ready_o   (in_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  hfc_datapath #(
    .STACK_TOP_INDEX (STACK_TOP_INDEX),
    .MAX_TASKS       (MAX_TASKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_i.payload),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.payload)
  );

endmodule

// File: tb/heartbeat_frame_collector_top_tb.sv
// testbench for heartbeat_frame_collector_top: directed and random push and tick words,
// a built-in predictor of the frame and error words, and a scoreboard on the output channel
// depends on rtl/hfc_pkg.sv, rtl/hfc_if.sv and rtl/heartbeat_frame_collector_top.sv
`timescale 1ns / 1ps

module heartbeat_frame_collector_top_tb;
  import hfc_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 12;
  localparam int unsigned STACK_TOP = 128;
  localparam int unsigned TASK_LIMIT = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 600;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int COUNT_TICKS = 9;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hfc_in_if in_if ();
  hfc_out_if out_if ();

  heartbeat_frame_collector_top #(
    .STACK_TOP_INDEX(STACK_TOP),
    .MAX_TASKS      (TASK_LIMIT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  logic [7:0] stk_mem [0:STACK_TOP];
  int unsigned stk_fill = 0;
  logic [15:0] done_flags = '0;
  bit tasks_finished = 1'b0;
  logic [15:0] collect_cnt = '0;
  logic [15:0] idle_cnt = '0;
  logic [31:0] due_time = '0;
  logic [19:0] cfg_interval = INTERVAL_RESET;
  logic [4:0] cfg_tasks = '0;
  logic [7:0] cfg_msg = '0;

  out_word_t item_words[$];
  out_word_t expected_words[$];

  int mismatches = 0;
  int cycle_cnt = 0;
  logic [31:0] now_cur = '0;

  // traffic shaping
  bit gaps_on = 1'b0;
  int burst_left = 0;
  stall_e stall_mode = STALL_NONE;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int pat_cnt = 0;

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  function automatic void stack_push(input logic [31:0] value, input int unsigned nbytes);
    out_word_t err;
    if (stk_fill + nbytes > STACK_TOP + 1) begin
      err = '0;
      err.kind = KIND_ERROR;
      item_words.push_back(err);
    end else begin
      for (int i = int'(nbytes) - 1; i >= 0; i--) begin
        stk_mem[stk_fill] = value[8*i +: 8];
        stk_fill++;
      end
    end
  endfunction

  function automatic void drain_frame();
    out_word_t w;
    logic [3:0][7:0] b;
    int unsigned c;
    stack_push(32'(idle_cnt), 2);
    stack_push(32'(collect_cnt), 2);
    stack_push(32'(cfg_msg), 1);
    while (stk_fill > 0) begin
      b = '0;
      c = 0;
      while (c < 4 && stk_fill > 0) begin
        stk_fill--;
        b[c] = stk_mem[stk_fill];
        c++;
      end
      w = '0;
      w.kind = KIND_DATA;
      w.byte_a = b[0];
      w.byte_b = b[1];
      w.byte_c = b[2];
      w.byte_d = b[3];
      w.byte_count = 3'(c);
      item_words.push_back(w);
    end
  endfunction

  function automatic void tick_update(input logic [15:0] mask, input logic [31:0] now);
    int unsigned ntasks;
    ntasks = (cfg_tasks > TASK_LIMIT) ? TASK_LIMIT : int'(cfg_tasks);
    if (!tasks_finished) begin
      collect_cnt++;
      tasks_finished = 1'b1;
      for (int i = 0; i < int'(ntasks); i++) begin
        if (!done_flags[i]) begin
          if (mask[i]) done_flags[i] = 1'b1;
          else tasks_finished = 1'b0;
        end
      end
    end
    if (tasks_finished) begin
      if (now >= due_time) begin
        drain_frame();
        due_time = now + 32'(cfg_interval);
        collect_cnt = '0;
        idle_cnt = '0;
        done_flags = '0;
        tasks_finished = 1'b0;
      end else begin
        idle_cnt++;
      end
    end
  endfunction

  function automatic void predict_word(input in_word_t w);
    item_words.delete();
    case (opcode_e'(w.opcode))
      OP_PUSH8: stack_push(w.push_value, 1);
      OP_PUSH16: stack_push(w.push_value, 2);
      OP_PUSH32: stack_push(w.push_value, 4);
      default: tick_update(w.done_mask, w.now_us);
    endcase
    if (item_words.size() != 0) item_words[item_words.size() - 1].last = 1'b1;
    foreach (item_words[i]) expected_words.push_back(item_words[i]);
  endfunction

  function automatic string show(input out_word_t w);
    return $sformatf("kind %0d bytes %h %h %h %h count %0d last %0d",
                     w.kind, w.byte_a, w.byte_b, w.byte_c, w.byte_d, w.byte_count, w.last);
  endfunction

  function automatic in_word_t push_item(input opcode_e op, input logic [31:0] value);
    in_word_t w;
    w = '0;
    w.opcode = op;
    w.push_value = value;
    w.done_mask = 16'($urandom);
    w.now_us = $urandom;
    return w;
  endfunction

  function automatic in_word_t tick_item(input logic [15:0] mask, input logic [31:0] now);
    in_word_t w;
    w = '0;
    w.opcode = OP_TICK;
    w.push_value = $urandom;
    w.done_mask = mask;
    w.now_us = now;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_word(w);
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDX_INTERVAL: cfg_interval = data;
      CFG_IDX_TASKS: cfg_tasks = data[4:0];
      CFG_IDX_MESSAGE: cfg_msg = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // receiver ready pattern and long hold-off
  always @(posedge clk_i) begin
    pat_cnt++;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
        STALL_PATTERN: out_if.ready <= ((pat_cnt % 11) < 7);
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected word at %0t: %s", $time, show(out_if.payload));
      end else begin
        if (out_if.payload.kind !== expected_words[0].kind ||
            out_if.payload.byte_a !== expected_words[0].byte_a ||
            out_if.payload.byte_b !== expected_words[0].byte_b ||
            out_if.payload.byte_c !== expected_words[0].byte_c ||
            out_if.payload.byte_d !== expected_words[0].byte_d ||
            out_if.payload.byte_count !== expected_words[0].byte_count ||
            out_if.payload.last !== expected_words[0].last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: expected %s, got %s", $time,
                     show(expected_words[0]), show(out_if.payload));
        end
        void'(expected_words.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_word(tick_item(16'h0000, 32'd0));
    send_word(tick_item(16'hFFFF, 32'd99999));
    send_word(tick_item(16'h0000, 32'd100000));
    settle();
  endtask

  task automatic test_push_widths();
    send_word(push_item(OP_PUSH8, 32'hFFFFFF00));
    send_word(push_item(OP_PUSH8, 32'h000000FF));
    send_word(push_item(OP_PUSH16, 32'h1234ABCD));
    send_word(push_item(OP_PUSH32, 32'hFFFFFFFF));
    send_word(push_item(OP_PUSH32, 32'h00000000));
    send_word(push_item(OP_PUSH32, 32'hDEADBEEF));
    send_word(push_item(OP_PUSH16, 32'h0000FFFF));
    // due time wraps past zero
    send_word(tick_item(16'h0000, 32'hFFFFFFFF));
    send_word(tick_item(16'h0000, 32'h00000000));
    send_word(tick_item(16'h0000, 32'd99999));
    settle();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_IDX_INTERVAL, 20'd0);
    write_reg(CFG_IDX_TASKS, 20'd16);
    write_reg(CFG_IDX_MESSAGE, 20'hFFFFF);
    write_reg(CFG_IDX_UNUSED, 20'hFFFFF);
    send_word(tick_item(16'h00FF, 32'd0));
    send_word(tick_item(16'hFF00, 32'hFFFFFFFF));
    send_word(tick_item(16'hFFFF, 32'hFFFFFFFF));
    settle();
    write_reg(CFG_IDX_TASKS, 20'd17);
    send_word(tick_item(16'hFFFF, 32'hFFFFFFFF));
    send_word(tick_item(16'hFFFF, 32'hFFFFFFFF));
    settle();
    write_reg(CFG_IDX_TASKS, 20'd31);
    send_word(tick_item(16'hFFFF, 32'hFFFFFFFF));
    settle();
    write_reg(CFG_IDX_TASKS, 20'd1);
    write_reg(CFG_IDX_INTERVAL, 20'd1000000);
    write_reg(CFG_IDX_MESSAGE, 20'd0);
    send_word(tick_item(16'h0001, 32'hFFFFFFFF));
    settle();
    write_reg(CFG_IDX_INTERVAL, 20'd1);
    send_word(tick_item(16'h0001, 32'd0));
    send_word(tick_item(16'h0001, 32'd999999));
    settle();
  endtask

  task automatic test_stack_overflow_pressure();
    write_reg(CFG_IDX_TASKS, 20'd1);
    write_reg(CFG_IDX_INTERVAL, 20'd0);
    write_reg(CFG_IDX_MESSAGE, 20'h5A);
    gaps_on = 1'b0;
    stall_mode = STALL_PATTERN;
    hold_req++;
    repeat (32) send_word(push_item(OP_PUSH32, $urandom));
    send_word(push_item(OP_PUSH16, $urandom));
    send_word(push_item(OP_PUSH8, $urandom));
    send_word(push_item(OP_PUSH8, $urandom));
    repeat (3) send_word(push_item(OP_PUSH32, $urandom));
    // full stack: all three heartbeat pushes overflow, then the longest drain
    send_word(tick_item(16'h0001, 32'hFFFFFFFF));
    settle();
  endtask

  task automatic test_tick_counters();
    gaps_on = 1'b0;
    stall_mode = STALL_NONE;
    write_reg(CFG_IDX_INTERVAL, 20'd1000000);
    write_reg(CFG_IDX_TASKS, 20'd17);
    repeat (COUNT_TICKS) send_word(tick_item(16'hFFFF, $urandom));
    settle();
    write_reg(CFG_IDX_TASKS, 20'd1);
    send_word(tick_item(16'h0000, 32'hFFFFFFFF));
    settle();
    write_reg(CFG_IDX_TASKS, 20'd0);
    repeat (COUNT_TICKS) send_word(tick_item(16'($urandom), $urandom_range(0, 999997)));
    send_word(tick_item(16'h0000, 32'hFFFFFFFF));
    settle();
  endtask

  task automatic run_phase(input logic [19:0] interval, input logic [4:0] tasks,
                           input int push_pct, input bit sparse, input stall_e stall,
                           input bit gaps);
    in_word_t w;
    int pick;
    write_reg(CFG_IDX_INTERVAL, interval);
    write_reg(CFG_IDX_TASKS, 20'(tasks));
    write_reg(CFG_IDX_MESSAGE, 20'($urandom_range(0, 255)));
    stall_mode = stall;
    gaps_on = gaps;
    burst_left = $urandom_range(1, 12);
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        w = push_item(opcode_e'($urandom_range(0, 2)), $urandom);
      end else begin
        w = tick_item(16'($urandom), $urandom);
        if (sparse) w.done_mask = 16'($urandom & $urandom & $urandom);
        else if ($urandom_range(0, 1) != 0) w.done_mask = 16'($urandom | $urandom);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          now_cur += $urandom_range(0, 2 * int'(interval) + 2);
          w.now_us = now_cur;
        end else if (pick == 7) begin
          w.now_us = '1;
        end
      end
      send_word(w);
    end
    settle();
  endtask

  task automatic test_random_phases();
    run_phase(20'd40, 5'd4, 50, 1'b0, STALL_RANDOM, 1'b1);
    run_phase(20'd1000, 5'd16, 75, 1'b1, STALL_PATTERN, 1'b1);
    run_phase(20'd0, 5'd0, 60, 1'b0, STALL_NONE, 1'b0);
    run_phase(20'd7, 5'd2, 40, 1'b0, STALL_RANDOM, 1'b1);
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_push_widths();
    test_config_extremes();
    test_stack_overflow_pressure();
    test_tick_counters();
    test_random_phases();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
